// File: src/pls_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    // List depth; the cell row and all counters follow from it.
    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int LEN_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 8;
    localparam int LEN_OUT_W = 5;
    localparam int DATA_W    = 32;
    localparam int CMP_W     = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_POS   = 3'd1;
    localparam logic [2:0] CMD_INS_BACK  = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_POS   = 3'd4;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd5;
    localparam logic [2:0] CMD_DISPLAY   = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_BADPOS = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_SHOWN  = 3'd4;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_cmd;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] element;
        logic [LEN_OUT_W-1:0]     length_now;
        logic                     last;
    } t_result;

    // What the cell row does at each clock edge
    typedef enum logic [1:0] {
        K_HOLD   = 2'd0,
        K_INSERT = 2'd1,
        K_DELETE = 2'd2,
        K_ROTATE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         pos;
        logic [IDX_W-1:0]         len_m1;
        logic signed [DATA_W-1:0] value;
    } t_bcast;

endpackage

`default_nettype wire

// File: src/pls_cell.sv
// One storage cell of the list row: holds one entry and takes a neighbor's entry when the row shifts.
`timescale 1ns / 1ps
`default_nettype none

module pls_cell (
    input  wire logic                             i_clk,
    input  wire logic [pls_pkg::IDX_W-1:0]        i_index,
    input  wire pls_pkg::t_bcast                  i_bcast,
    input  wire logic signed [pls_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [pls_pkg::DATA_W-1:0] i_right,
    input  wire logic signed [pls_pkg::DATA_W-1:0] i_head,
    output logic signed [pls_pkg::DATA_W-1:0]      o_data
);
    import pls_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_bcast.kind)
            K_INSERT: begin
                if (i_index == i_bcast.pos) begin
                    n_data = i_bcast.value;
                end else if (i_index > i_bcast.pos) begin
                    n_data = i_left;
                end
            end
            K_DELETE: begin
                if (i_index >= i_bcast.pos) begin
                    n_data = i_right;
                end
            end
            K_ROTATE: begin
                // the last live cell takes the front entry back
                if (i_index == i_bcast.len_m1) begin
                    n_data = i_head;
                end else if (i_index < i_bcast.len_m1) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: src/positional_list_store_top.sv
// Top level of the positional list store: command decode and the row of cells.
// Insert and delete: result strobe in the cycle after the transfer; one command per cycle unless busy.
// Display of n elements: first result from the strobe register after the state enters S_SHOW,
//   one per cycle after, busy high while the cell row rotates the list past the front cell.
// Display of an empty list answers like insert and delete, one result in the cycle after.
// Reset (synchronous, active low) empties the list and idles the block; the receiver
//   cannot stall, so every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire pls_pkg::t_cmd  i_cmd,
    output logic                busy,
    output logic                o_strobe,
    output pls_pkg::t_result    o_result
);
    import pls_pkg::*;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SHOW = 1'b1
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_strobe, n_strobe;
    t_result          r_res, n_res;

    t_bcast           bcast;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] ins_pos;
    logic [CMP_W-1:0] del_pos;
    logic             is_ins;
    logic             is_del;
    logic             show_last;

    // cell row wiring: cell_data[CAPACITY] feeds the last cell's right side
    logic signed [DATA_W-1:0] cell_data [CAPACITY+1];

    assign cell_data[CAPACITY] = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        if (gi == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_rest
            assign left_in = cell_data[gi-1];
        end
        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(gi)),
            .i_bcast (bcast),
            .i_left  (left_in),
            .i_right (cell_data[gi+1]),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[gi])
        );
    end

    assign len_ext   = CMP_W'(r_len);
    assign show_last = (LEN_W'(r_cnt + 1'b1) == r_len);

    // Pick the target position for each command
    always_comb begin
        is_ins  = 1'b0;
        is_del  = 1'b0;
        ins_pos = '0;
        del_pos = '0;
        case (i_cmd.command)
            CMD_INS_FRONT: begin
                is_ins = 1'b1;
            end
            CMD_INS_POS: begin
                is_ins  = 1'b1;
                ins_pos = CMP_W'(i_cmd.position);
            end
            CMD_INS_BACK: begin
                is_ins  = 1'b1;
                ins_pos = len_ext;
            end
            CMD_DEL_FRONT: begin
                is_del = 1'b1;
            end
            CMD_DEL_POS: begin
                is_del  = 1'b1;
                del_pos = CMP_W'(i_cmd.position);
            end
            CMD_DEL_BACK: begin
                is_del  = 1'b1;
                del_pos = len_ext - 1'b1;
            end
            default: begin
                is_ins = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_res    = r_res;

        bcast.kind   = K_HOLD;
        bcast.pos    = '0;
        bcast.len_m1 = IDX_W'(r_len - 1'b1);
        bcast.value  = i_cmd.value;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_strobe       = 1'b1;
                    n_res.status   = ST_OK;
                    n_res.element  = '0;
                    n_res.last     = 1'b1;
                    if (is_ins) begin
                        // full is checked before the position
                        if (r_len == LEN_W'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else if (ins_pos > len_ext) begin
                            n_res.status = ST_BADPOS;
                        end else begin
                            bcast.kind = K_INSERT;
                            bcast.pos  = IDX_W'(ins_pos);
                            n_len      = r_len + 1'b1;
                        end
                    end else if (is_del) begin
                        if (r_len == '0) begin
                            n_res.status = ST_EMPTY;
                        end else if (del_pos >= len_ext) begin
                            n_res.status = ST_BADPOS;
                        end else begin
                            bcast.kind = K_DELETE;
                            bcast.pos  = IDX_W'(del_pos);
                            n_len      = r_len - 1'b1;
                        end
                    end else if (i_cmd.command == CMD_DISPLAY) begin
                        if (r_len == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            // results come from the show state
                            n_strobe = 1'b0;
                            n_state  = S_SHOW;
                            n_cnt    = '0;
                        end
                    end
                    n_res.length_now = LEN_OUT_W'(n_len);
                end
            end
            S_SHOW: begin
                // emit the front cell, rotate the live part of the row
                bcast.kind       = K_ROTATE;
                n_strobe         = 1'b1;
                n_res.status     = ST_SHOWN;
                n_res.element    = cell_data[0];
                n_res.length_now = LEN_OUT_W'(r_len);
                n_res.last       = show_last;
                if (show_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
        r_res <= n_res;
    end

    assign busy     = (r_state == S_SHOW);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.command != CMD_DISPLAY) |=> (o_strobe && o_result.last))
        else $error("non-display command did not give one final result");

    a_show_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |-> (r_len != '0 && r_cnt < r_len))
        else $error("display counter outside the list");

    a_show_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |=> $stable(r_len))
        else $error("length changed during display");

    a_shown_from_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_SHOWN) |-> $past(r_state == S_SHOW))
        else $error("element shown outside display");
`endif

endmodule

`default_nettype wire
